// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bcpd_pkg.sv =====
// Package for the balance drive controller: widths, constants, codes and types.
// No dependencies; used by every module of the block.
package bcpd_pkg;

    localparam int GAIN_FRAC_BITS  = 12;
    localparam int STATE_FRAC_BITS = 8;

    // filtered speed and integral magnitude stay below 2^(16+SFB)
    localparam int STATE_W = 18 + STATE_FRAC_BITS;
    localparam int B_W     = STATE_W + 1;
    localparam int A_W     = 32;
    localparam int PROD_W  = A_W + B_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam longint COEF_KEEP_I = (7 * (longint'(1) << GAIN_FRAC_BITS) + 5) / 10;
    localparam longint COEF_TAKE_I = (longint'(1) << GAIN_FRAC_BITS) - COEF_KEEP_I;
    localparam logic signed [A_W-1:0] COEF_KEEP = A_W'(COEF_KEEP_I);
    localparam logic signed [A_W-1:0] COEF_TAKE = A_W'(COEF_TAKE_I);

    localparam logic [11:0] TILT_CLEAR = 12'd400;

    // register indexes
    localparam logic [2:0] REG_ZERO_ANGLE     = 3'd0;
    localparam logic [2:0] REG_UPRIGHT_KP     = 3'd1;
    localparam logic [2:0] REG_UPRIGHT_KD     = 3'd2;
    localparam logic [2:0] REG_SPEED_KP       = 3'd3;
    localparam logic [2:0] REG_SPEED_KI       = 3'd4;
    localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd5;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;
    localparam logic [2:0] REG_CUTOFF_ANGLE   = 3'd7;

    // register reset values
    localparam logic signed [11:0] RST_ZERO_ANGLE     = -12'sd55;
    localparam logic signed [31:0] RST_UPRIGHT_KP     = -32'sd172032;
    localparam logic signed [31:0] RST_UPRIGHT_KD     = 32'sd2703;
    localparam logic signed [31:0] RST_SPEED_KP       = 32'sd4096;
    localparam logic signed [31:0] RST_SPEED_KI       = 32'sd20;
    localparam logic [14:0]        RST_DRIVE_LIMIT    = 15'd7200;
    localparam logic [15:0]        RST_INTEGRAL_LIMIT = 16'd10000;
    localparam logic [10:0]        RST_CUTOFF_ANGLE   = 11'd800;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_P,
        ST_UP_D,
        ST_UP_ACC,
        ST_UP_RND,
        ST_F_TAKE,
        ST_F_ACC,
        ST_F_RND,
        ST_INT_ADD,
        ST_INT_CLAMP,
        ST_S_I,
        ST_S_ACC,
        ST_S_RND,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP_ERR,
        MUL_KD_GYRO,
        MUL_FILT_KEEP,
        MUL_SPD_TAKE,
        MUL_FILT_SKP,
        MUL_INT_KI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     ld_upright;
        logic     ld_filt;
        logic     ld_isum;
        logic     ld_integ;
        logic     ld_speed;
        logic     finish;
    } ctl_t;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
        logic signed [15:0] r;
        if (x > ACC_W'(signed'(32767))) begin
            r = 16'sh7FFF;
        end else if (x < -ACC_W'(signed'(32768))) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bcpd_mac.sv =====
// Shared multiply-accumulate unit: registered signed product, then accumulator.
// Depends on bcpd_pkg for widths and the control struct.
module bcpd_mac (
    input  logic                                  aclk,
    input  bcpd_pkg::ctl_t                        ctl,
    input  logic signed [bcpd_pkg::A_W-1:0]       op_a,
    input  logic signed [bcpd_pkg::B_W-1:0]       op_b,
    output logic signed [bcpd_pkg::ACC_W-1:0]     acc
);

    logic signed [bcpd_pkg::PROD_W-1:0] prod_reg;
    logic signed [bcpd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [bcpd_pkg::ACC_W-1:0]  acc_next;
    logic signed [bcpd_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = bcpd_pkg::ACC_W'(prod_reg);

    always_comb begin
        case (ctl.acc_op)
            bcpd_pkg::ACC_LOAD: acc_next = prod_ext;
            bcpd_pkg::ACC_ADD:  acc_next = acc_reg + prod_ext;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= bcpd_pkg::PROD_W'(op_a) * bcpd_pkg::PROD_W'(op_b);
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== design/bcpd_seq.sv =====
// Sequencer stepping one item through the shared multiply-accumulate unit.
// Depends on bcpd_pkg for the state enum and control struct.
module bcpd_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           out_free,
    output logic           s_ready,
    output bcpd_pkg::ctl_t ctl
);

    bcpd_pkg::state_t state_reg;
    bcpd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bcpd_pkg::ST_IDLE:      if (s_valid) state_next = bcpd_pkg::ST_UP_P;
            bcpd_pkg::ST_UP_P:      state_next = bcpd_pkg::ST_UP_D;
            bcpd_pkg::ST_UP_D:      state_next = bcpd_pkg::ST_UP_ACC;
            bcpd_pkg::ST_UP_ACC:    state_next = bcpd_pkg::ST_UP_RND;
            bcpd_pkg::ST_UP_RND:    state_next = bcpd_pkg::ST_F_TAKE;
            bcpd_pkg::ST_F_TAKE:    state_next = bcpd_pkg::ST_F_ACC;
            bcpd_pkg::ST_F_ACC:     state_next = bcpd_pkg::ST_F_RND;
            bcpd_pkg::ST_F_RND:     state_next = bcpd_pkg::ST_INT_ADD;
            bcpd_pkg::ST_INT_ADD:   state_next = bcpd_pkg::ST_INT_CLAMP;
            bcpd_pkg::ST_INT_CLAMP: state_next = bcpd_pkg::ST_S_I;
            bcpd_pkg::ST_S_I:       state_next = bcpd_pkg::ST_S_ACC;
            bcpd_pkg::ST_S_ACC:     state_next = bcpd_pkg::ST_S_RND;
            bcpd_pkg::ST_S_RND:     state_next = bcpd_pkg::ST_FINISH;
            bcpd_pkg::ST_FINISH:    if (out_free) state_next = bcpd_pkg::ST_IDLE;
            default:                state_next = bcpd_pkg::ST_IDLE;
        endcase
    end

    // product is registered, so each LOAD/ADD comes in the state after its multiply
    always_comb begin
        ctl         = '0;
        ctl.mul_sel = bcpd_pkg::MUL_NONE;
        ctl.acc_op  = bcpd_pkg::ACC_HOLD;
        s_ready     = 1'b0;
        case (state_reg)
            bcpd_pkg::ST_IDLE: begin
                s_ready = aresetn;
            end
            bcpd_pkg::ST_UP_P: begin
                ctl.mul_sel = bcpd_pkg::MUL_KP_ERR;
            end
            bcpd_pkg::ST_UP_D: begin
                ctl.mul_sel = bcpd_pkg::MUL_KD_GYRO;
                ctl.acc_op  = bcpd_pkg::ACC_LOAD;
            end
            bcpd_pkg::ST_UP_ACC: begin
                ctl.acc_op = bcpd_pkg::ACC_ADD;
            end
            bcpd_pkg::ST_UP_RND: begin
                ctl.ld_upright = 1'b1;
                ctl.mul_sel    = bcpd_pkg::MUL_FILT_KEEP;
            end
            bcpd_pkg::ST_F_TAKE: begin
                ctl.mul_sel = bcpd_pkg::MUL_SPD_TAKE;
                ctl.acc_op  = bcpd_pkg::ACC_LOAD;
            end
            bcpd_pkg::ST_F_ACC: begin
                ctl.acc_op = bcpd_pkg::ACC_ADD;
            end
            bcpd_pkg::ST_F_RND: begin
                ctl.ld_filt = 1'b1;
            end
            bcpd_pkg::ST_INT_ADD: begin
                ctl.ld_isum = 1'b1;
                ctl.mul_sel = bcpd_pkg::MUL_FILT_SKP;
            end
            bcpd_pkg::ST_INT_CLAMP: begin
                ctl.ld_integ = 1'b1;
                ctl.acc_op   = bcpd_pkg::ACC_LOAD;
            end
            bcpd_pkg::ST_S_I: begin
                ctl.mul_sel = bcpd_pkg::MUL_INT_KI;
            end
            bcpd_pkg::ST_S_ACC: begin
                ctl.acc_op = bcpd_pkg::ACC_ADD;
            end
            bcpd_pkg::ST_S_RND: begin
                ctl.ld_speed = 1'b1;
            end
            bcpd_pkg::ST_FINISH: begin
                ctl.finish = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/balance_cascade_pd_pi_drive_top.sv =====
// Balance drive controller top: registers, loop state, operand select, output stage.
// Items do not overlap: a new item is accepted only after the last has left FINISH,
// as the single shared multiply-accumulate unit is stepped by the sequencer.
// The output register frees the next accept while a result waits to be taken.
// Reset (aresetn, synchronous, active low): registers to defaults, loop state to 0.
// Depends on bcpd_pkg, bcpd_seq, bcpd_mac and assert_macros.svh.
`include "assert_macros.svh"

module balance_cascade_pd_pi_drive_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [11:0] s_pitch_angle,
    input  logic signed [15:0] s_gyro_rate,
    input  logic signed [15:0] s_wheel_speed_a,
    input  logic signed [15:0] s_wheel_speed_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_drive,
    output logic               m_was_clamped,
    output logic               m_tilt_shutoff
);

    localparam int SW  = bcpd_pkg::STATE_W;
    localparam int BW  = bcpd_pkg::B_W;
    localparam int AW  = bcpd_pkg::A_W;
    localparam int CW  = bcpd_pkg::ACC_W;
    localparam int GFB = bcpd_pkg::GAIN_FRAC_BITS;
    localparam int SFB = bcpd_pkg::STATE_FRAC_BITS;

    localparam logic signed [CW-1:0] HALF_UP = CW'(1) <<< (GFB - 1);
    localparam logic signed [CW-1:0] HALF_SP = CW'(1) <<< (GFB + SFB - 1);

    // configuration registers
    logic signed [11:0] zero_angle_reg;
    logic signed [31:0] upright_kp_reg;
    logic signed [31:0] upright_kd_reg;
    logic signed [31:0] speed_kp_reg;
    logic signed [31:0] speed_ki_reg;
    logic [14:0]        drive_limit_reg;
    logic [15:0]        integral_limit_reg;
    logic [10:0]        cutoff_angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_angle_reg     <= bcpd_pkg::RST_ZERO_ANGLE;
            upright_kp_reg     <= bcpd_pkg::RST_UPRIGHT_KP;
            upright_kd_reg     <= bcpd_pkg::RST_UPRIGHT_KD;
            speed_kp_reg       <= bcpd_pkg::RST_SPEED_KP;
            speed_ki_reg       <= bcpd_pkg::RST_SPEED_KI;
            drive_limit_reg    <= bcpd_pkg::RST_DRIVE_LIMIT;
            integral_limit_reg <= bcpd_pkg::RST_INTEGRAL_LIMIT;
            cutoff_angle_reg   <= bcpd_pkg::RST_CUTOFF_ANGLE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bcpd_pkg::REG_ZERO_ANGLE:     zero_angle_reg     <= cfg_wdata[11:0];
                bcpd_pkg::REG_UPRIGHT_KP:     upright_kp_reg     <= cfg_wdata;
                bcpd_pkg::REG_UPRIGHT_KD:     upright_kd_reg     <= cfg_wdata;
                bcpd_pkg::REG_SPEED_KP:       speed_kp_reg       <= cfg_wdata;
                bcpd_pkg::REG_SPEED_KI:       speed_ki_reg       <= cfg_wdata;
                bcpd_pkg::REG_DRIVE_LIMIT:    drive_limit_reg    <= cfg_wdata[14:0];
                bcpd_pkg::REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata[15:0];
                bcpd_pkg::REG_CUTOFF_ANGLE:   cutoff_angle_reg   <= cfg_wdata[10:0];
                default:                      zero_angle_reg     <= zero_angle_reg;
            endcase
        end
    end

    // sequencer
    bcpd_pkg::ctl_t ctl;
    logic           out_free;
    logic           m_valid_reg;
    logic           s_accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    bcpd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    // item capture, with angle error and wheel sum formed up front
    logic signed [11:0] pitch_reg;
    logic signed [15:0] gyro_reg;
    logic signed [12:0] err_reg;
    logic signed [16:0] ssum_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pitch_reg <= s_pitch_angle;
            gyro_reg  <= s_gyro_rate;
            err_reg   <= 13'(zero_angle_reg) - 13'(s_pitch_angle);
            ssum_reg  <= 17'(s_wheel_speed_a) + 17'(s_wheel_speed_b);
        end
    end

    // operand select for the shared unit
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [CW-1:0] acc;
    logic signed [SW-1:0] filt_reg;
    logic signed [SW-1:0] integ_reg;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctl.mul_sel)
            bcpd_pkg::MUL_KP_ERR: begin
                op_a = upright_kp_reg;
                op_b = BW'(err_reg);
            end
            bcpd_pkg::MUL_KD_GYRO: begin
                op_a = upright_kd_reg;
                op_b = BW'(gyro_reg);
            end
            bcpd_pkg::MUL_FILT_KEEP: begin
                op_a = bcpd_pkg::COEF_KEEP;
                op_b = BW'(filt_reg);
            end
            bcpd_pkg::MUL_SPD_TAKE: begin
                op_a = bcpd_pkg::COEF_TAKE;
                op_b = BW'(ssum_reg) <<< SFB;
            end
            bcpd_pkg::MUL_FILT_SKP: begin
                op_a = speed_kp_reg;
                op_b = BW'(filt_reg);
            end
            bcpd_pkg::MUL_INT_KI: begin
                op_a = speed_ki_reg;
                op_b = BW'(integ_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    bcpd_mac u_mac (
        .aclk (aclk),
        .ctl  (ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // rounding shifts of the accumulator
    logic signed [CW-1:0] rnd_up;
    logic signed [CW-1:0] rnd_sp;

    assign rnd_up = (acc + HALF_UP) >>> GFB;
    assign rnd_sp = (acc + HALF_SP) >>> (GFB + SFB);

    // tilt magnitude
    logic [11:0] pitch_abs;
    logic        tilt_clear;
    logic        shut;

    assign pitch_abs  = pitch_reg[11] ? 12'(-pitch_reg) : 12'(pitch_reg);
    assign tilt_clear = pitch_abs > bcpd_pkg::TILT_CLEAR;
    assign shut       = pitch_abs >= 12'(cutoff_angle_reg);

    // loop state and term registers
    logic signed [15:0] upright_reg;
    logic signed [15:0] speed_reg;
    logic signed [SW:0] isum_reg;
    logic signed [SW:0] ilim;
    logic signed [SW:0] iclamp;
    logic signed [SW-1:0] integ_next;
    logic signed [SW-1:0] filt_next;

    assign ilim = signed'((SW + 1)'({integral_limit_reg, {SFB{1'b0}}}));

    always_comb begin
        if (isum_reg > ilim) begin
            iclamp = ilim;
        end else if (isum_reg < -ilim) begin
            iclamp = -ilim;
        end else begin
            iclamp = isum_reg;
        end
    end

    always_comb begin
        filt_next  = filt_reg;
        integ_next = integ_reg;
        if (ctl.ld_filt) begin
            filt_next = rnd_up[SW-1:0];
        end
        if (ctl.ld_integ) begin
            integ_next = iclamp[SW-1:0];
        end else if (ctl.ld_speed && tilt_clear) begin
            integ_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg  <= '0;
            integ_reg <= '0;
        end else begin
            filt_reg  <= filt_next;
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_upright) begin
            upright_reg <= bcpd_pkg::sat16(rnd_up);
        end
        if (ctl.ld_isum) begin
            isum_reg <= (SW + 1)'(integ_reg) + (SW + 1)'(filt_reg);
        end
        if (ctl.ld_speed) begin
            speed_reg <= bcpd_pkg::sat16(rnd_sp);
        end
    end

    // final sum, limit clamp and tilt cutoff
    logic signed [16:0] sum;
    logic signed [16:0] lim;
    logic signed [16:0] clip_hi;
    logic signed [16:0] clip;
    logic               clamped;
    logic               out_load;

    assign sum     = 17'(upright_reg) + 17'(speed_reg);
    assign lim     = signed'({2'b00, drive_limit_reg});
    assign clip_hi = (sum >= lim) ? lim : sum;
    assign clip    = (clip_hi <= -lim) ? -lim : clip_hi;
    assign clamped = clip != sum;
    assign out_load = ctl.finish && out_free;

    logic signed [15:0] drive_reg;
    logic               clamped_reg;
    logic               shut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            drive_reg   <= shut ? 16'sd0 : clip[15:0];
            clamped_reg <= clamped;
            shut_reg    <= shut;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive        = drive_reg;
    assign m_was_clamped  = clamped_reg;
    assign m_tilt_shutoff = shut_reg;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `ASSERT_SAME(a_shutoff_zero, aclk, aresetn, m_valid && m_tilt_shutoff, m_drive == 16'sd0, "shutoff drive not zero")
    `ASSERT_SAME(a_drive_range, aclk, aresetn, m_valid, m_drive != 16'sh8000, "drive out of range")
    `ASSERT_SAME(a_no_ready_while_busy, aclk, aresetn, ctl.finish, !s_ready, "ready while finishing")

endmodule
